// ===== hw/rtl/thr_pkg.sv =====
// thr_pkg: shared types and constants for the timestamped history ring
// transaction structs, stored record layout, state machine encoding
// no dependencies
package thr_pkg;

   localparam int HISTORY_DEPTH = 256;
   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int TIME_W = 32;

   localparam logic REQ_SAVE = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] stamp;
      logic [31:0] origin_x;
      logic [31:0] origin_y;
      logic [31:0] origin_z;
      logic [31:0] speed_x;
      logic [31:0] speed_y;
      logic [31:0] speed_z;
      logic [31:0] angle_x;
      logic [31:0] angle_y;
      logic [31:0] angle_z;
      logic [15:0] motion_word;
   } req_item_type;

   typedef struct packed {
      logic        found;
      logic [31:0] got_origin_x;
      logic [31:0] got_origin_y;
      logic [31:0] got_origin_z;
      logic [31:0] got_speed_x;
      logic [31:0] got_speed_y;
      logic [31:0] got_speed_z;
      logic [31:0] got_angle_x;
      logic [31:0] got_angle_y;
      logic [31:0] got_angle_z;
      logic [15:0] got_motion_word;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] origin_x;
      logic [31:0] origin_y;
      logic [31:0] origin_z;
      logic [31:0] speed_x;
      logic [31:0] speed_y;
      logic [31:0] speed_z;
      logic [31:0] angle_x;
      logic [31:0] angle_y;
      logic [31:0] angle_z;
      logic [15:0] motion;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
   } mem_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SAVE_CHK,
      ST_SCAN
   } thr_state_type;

endpackage

// ===== hw/rtl/thr_ram.sv =====
// thr_ram: generic single port synchronous ram, registered read
// no dependencies
module thr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/thr_ctrl.sv =====
// thr_ctrl: sequencer for save and lookup transactions, ring pointer, fill count
// depends on thr_pkg; drives the time and record rams through one shared port
module thr_ctrl import thr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_data,
   output logic         rsp_valid,
   output rsp_item_type rsp_data,
   output mem_req_type  mem_req,
   output logic [TIME_W-1:0] wr_time,
   output rec_type      wr_rec,
   input  logic [TIME_W-1:0] rd_time,
   input  rec_type      rd_rec
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);

   thr_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0] stamp_ff, stamp_in;
   rec_type           rec_ff, rec_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]  prev_slot, prev_addr, next_slot;
   logic              entry_live, hit, last;
   logic [TIME_W-1:0] time_eff;
   rec_type           rec_eff;

   assign prev_slot  = (slot_ff == '0) ? LAST_IDX : slot_ff - IDX_W'(1);
   assign next_slot  = (slot_ff == LAST_IDX) ? '0 : slot_ff + IDX_W'(1);
   assign prev_addr  = (addr_ff == '0) ? LAST_IDX : addr_ff - IDX_W'(1);
   // entries never written read as zero
   assign entry_live = CNT_W'(addr_ff) < fill_ff;
   assign time_eff   = entry_live ? rd_time : '0;
   assign rec_eff    = entry_live ? rd_rec : '0;
   assign hit        = $signed(time_eff) <= $signed(stamp_ff);
   assign last       = cnt_ff == FULL_CNT;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_data.req_type == REQ_SAVE) ? ST_SAVE_CHK : ST_SCAN;
            end
         end
         ST_SAVE_CHK: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (hit || last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      stamp_in     = stamp_ff;
      rec_in       = rec_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_req.we   = 1'b0;
      mem_req.addr = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            mem_req.addr = prev_slot;
            if (start) begin
               stamp_in         = req_data.stamp;
               rec_in.origin_x  = req_data.origin_x;
               rec_in.origin_y  = req_data.origin_y;
               rec_in.origin_z  = req_data.origin_z;
               rec_in.speed_x   = req_data.speed_x;
               rec_in.speed_y   = req_data.speed_y;
               rec_in.speed_z   = req_data.speed_z;
               rec_in.angle_x   = req_data.angle_x;
               rec_in.angle_y   = req_data.angle_y;
               rec_in.angle_z   = req_data.angle_z;
               rec_in.motion    = req_data.motion_word;
               addr_in          = prev_slot;
               cnt_in           = CNT_W'(1);
            end
         end
         ST_SAVE_CHK: begin
            // repeated time stamp drops the transaction
            if (time_eff != stamp_ff) begin
               mem_req.we   = 1'b1;
               mem_req.addr = slot_ff;
               slot_in      = next_slot;
               fill_in      = (fill_ff == FULL_CNT) ? fill_ff : fill_ff + CNT_W'(1);
            end
         end
         ST_SCAN: begin
            mem_req.addr = prev_addr;
            if (hit || last) begin
               rsp_valid_in = 1'b1;
               if (hit) begin
                  rsp_data_in.found           = 1'b1;
                  rsp_data_in.got_origin_x    = rec_eff.origin_x;
                  rsp_data_in.got_origin_y    = rec_eff.origin_y;
                  rsp_data_in.got_origin_z    = rec_eff.origin_z;
                  rsp_data_in.got_speed_x     = rec_eff.speed_x;
                  rsp_data_in.got_speed_y     = rec_eff.speed_y;
                  rsp_data_in.got_speed_z     = rec_eff.speed_z;
                  rsp_data_in.got_angle_x     = rec_eff.angle_x;
                  rsp_data_in.got_angle_y     = rec_eff.angle_y;
                  rsp_data_in.got_angle_z     = rec_eff.angle_z;
                  rsp_data_in.got_motion_word = rec_eff.motion;
               end else begin
                  rsp_data_in = '0;
               end
            end else begin
               addr_in = prev_addr;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            mem_req.addr = addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      cnt_ff      <= cnt_in;
      stamp_ff    <= stamp_in;
      rec_ff      <= rec_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign wr_time   = stamp_ff;
   assign wr_rec    = rec_ff;

endmodule

// ===== hw/rtl/timestamped_history_ring_top.sv =====
// timestamped_history_ring_top: ring of timestamped motion records
// depends on thr_pkg, thr_ram, thr_ctrl
//
// A transaction is accepted when start is high and busy is low. req_data.req_type
// selects save or lookup. A save compares the stamp with the newest entry and,
// if different, writes the record and advances the ring; it gives no response
// and keeps busy high through its check state. A lookup walks the ring from
// newest to oldest, one entry per cycle through the time ram and record ram,
// which share one read address; the record of the first entry whose time is at
// most the query (signed) is returned. The rsp_valid strobe is registered from
// the scan step that visits the last of the 1 to 256 entries visited; busy is
// low in the strobe cycle, so the next transaction is accepted at the edge that
// ends it. The response is shown for exactly one cycle and cannot be held off.
// Reset clears the ring pointer and the fill count; entries beyond the fill
// count read as zero time and zero record, so no clearing pass runs and the
// block is ready right after reset.
module timestamped_history_ring_top import thr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_data,
   output logic         rsp_valid,
   output rsp_item_type rsp_data
);

   mem_req_type       mem_req;
   logic [TIME_W-1:0] wr_time, rd_time;
   rec_type           wr_rec, rd_rec;

   thr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .wr_time   (wr_time),
      .wr_rec    (wr_rec),
      .rd_time   (rd_time),
      .rd_rec    (rd_rec)
   );

   thr_ram #(
      .WIDTH (TIME_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_time_ram (
      .clock (clock),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (wr_time),
      .rdata (rd_time)
   );

   thr_ram #(
      .WIDTH (REC_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_rec_ram (
      .clock (clock),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (wr_rec),
      .rdata (rd_rec)
   );

endmodule

// ===== hw/rtl/thr_checker.sv =====
// thr_checker: port level assertions for the timestamped history ring
// depends on thr_pkg; bound to timestamped_history_ring_top
module thr_checker import thr_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_item_type rsp_data
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not make block busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("response without a lookup in progress");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.got_origin_x == '0 && rsp_data.got_origin_y == '0 &&
         rsp_data.got_origin_z == '0 && rsp_data.got_speed_x == '0 &&
         rsp_data.got_speed_y == '0 && rsp_data.got_speed_z == '0 &&
         rsp_data.got_angle_x == '0 && rsp_data.got_angle_y == '0 &&
         rsp_data.got_angle_z == '0 && rsp_data.got_motion_word == '0)
      else $error("miss response carries nonzero record");

endmodule

bind timestamped_history_ring_top thr_checker u_thr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== tb/timestamped_history_ring_top_tb.sv =====
// timestamped_history_ring_top_tb: self-checking bench for the timestamped history ring
// directed probe table, then random save/lookup traffic checked against a ring predictor
// depends on thr_pkg and timestamped_history_ring_top
module timestamped_history_ring_top_tb import thr_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 700;
   localparam int SETTLE_CYCLES = 300;

   typedef enum logic [1:0] {
      FILL_ZERO,
      FILL_ONES,
      FILL_ALT,
      FILL_RAND
   } fill_kind_type;

   typedef struct packed {
      logic          kind;
      logic [31:0]   stamp;
      fill_kind_type fill;
      logic          fixed_exp;
      logic          exp_found;
      fill_kind_type exp_fill;
   } probe_row_type;

   localparam int N_PROBES = 21;
   localparam probe_row_type PROBES [0:N_PROBES-1] = '{
      '{REQ_LOOKUP, 32'h0000_0000, FILL_RAND, 1'b1, 1'b1, FILL_ZERO},
      '{REQ_LOOKUP, 32'hFFFF_FFFF, FILL_RAND, 1'b1, 1'b0, FILL_ZERO},
      '{REQ_LOOKUP, 32'h8000_0000, FILL_RAND, 1'b1, 1'b0, FILL_ZERO},
      '{REQ_LOOKUP, 32'h7FFF_FFFF, FILL_RAND, 1'b1, 1'b1, FILL_ZERO},
      '{REQ_SAVE,   32'h0000_0000, FILL_ONES, 1'b0, 1'b0, FILL_ZERO},
      '{REQ_LOOKUP, 32'h7FFF_FFFF, FILL_RAND, 1'b1, 1'b1, FILL_ZERO},
      '{REQ_SAVE,   32'h0000_0064, FILL_ONES, 1'b0, 1'b0, FILL_ZERO},
      '{REQ_SAVE,   32'h0000_0064, FILL_ZERO, 1'b0, 1'b0, FILL_ZERO},
      '{REQ_LOOKUP, 32'h0000_0064, FILL_RAND, 1'b1, 1'b1, FILL_ONES},
      '{REQ_LOOKUP, 32'h0000_0063, FILL_RAND, 1'b1, 1'b1, FILL_ZERO},
      '{REQ_LOOKUP, 32'hFFFF_FFFF, FILL_ZERO, 1'b1, 1'b0, FILL_ZERO},
      '{REQ_SAVE,   32'h7FFF_FFFF, FILL_RAND, 1'b0, 1'b0, FILL_ZERO},
      '{REQ_SAVE,   32'h8000_0000, FILL_ALT,  1'b0, 1'b0, FILL_ZERO},
      '{REQ_LOOKUP, 32'h8000_0000, FILL_ONES, 1'b1, 1'b1, FILL_ALT},
      '{REQ_LOOKUP, 32'hFFFF_FFFE, FILL_RAND, 1'b1, 1'b1, FILL_ALT},
      '{REQ_SAVE,   32'h0000_0000, FILL_RAND, 1'b0, 1'b0, FILL_ZERO},
      '{REQ_SAVE,   32'h0000_0000, FILL_ONES, 1'b0, 1'b0, FILL_ZERO},
      '{REQ_LOOKUP, 32'h7FFF_FFFF, FILL_RAND, 1'b0, 1'b0, FILL_ZERO},
      '{REQ_SAVE,   32'hFFFF_FFFB, FILL_RAND, 1'b0, 1'b0, FILL_ZERO},
      '{REQ_LOOKUP, 32'hFFFF_FFFA, FILL_RAND, 1'b1, 1'b1, FILL_ALT},
      '{REQ_LOOKUP, 32'h7FFF_FFFE, FILL_RAND, 1'b0, 1'b0, FILL_ZERO}
   };

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_data;
   logic         rsp_valid;
   rsp_item_type rsp_data;

   logic [31:0]      ring_time [HISTORY_DEPTH];
   rec_type          ring_rec [HISTORY_DEPTH];
   logic [IDX_W-1:0] ring_head;
   rsp_item_type     lookups_due [$];
   int               errors;
   int               cycles;
   logic             row_fixed;
   rsp_item_type     row_want;

   timestamped_history_ring_top dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_item_type build_req(logic kind, logic [31:0] stamp,
                                              fill_kind_type fill);
      rec_type body;
      case (fill)
         FILL_ZERO: body = '0;
         FILL_ONES: body = '1;
         FILL_ALT: body = {{9{32'hA5A5_5A5A}}, 16'h5A5A};
         default: begin
            body.origin_x = $urandom;
            body.origin_y = $urandom;
            body.origin_z = $urandom;
            body.speed_x = $urandom;
            body.speed_y = $urandom;
            body.speed_z = $urandom;
            body.angle_x = $urandom;
            body.angle_y = $urandom;
            body.angle_z = $urandom;
            body.motion = 16'($urandom);
         end
      endcase
      return {kind, stamp, body};
   endfunction

   // updates the ring copy and returns the lookup answer (zero for saves)
   function automatic rsp_item_type track_ring(req_item_type item);
      logic [IDX_W-1:0] idx;
      rsp_item_type answer;
      answer = '0;
      if (item.req_type == REQ_SAVE) begin
         if (ring_time[ring_head - 1'b1] != item.stamp) begin
            ring_time[ring_head] = item.stamp;
            ring_rec[ring_head] = item[REC_W-1:0];
            ring_head = ring_head + 1'b1;
         end
      end else begin
         for (int k = 1; k <= HISTORY_DEPTH; k++) begin
            idx = ring_head - IDX_W'(k);
            if ($signed(ring_time[idx]) <= $signed(item.stamp)) begin
               answer = {1'b1, ring_rec[idx]};
               break;
            end
         end
      end
      return answer;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type due;
      rsp_item_type answer;
      if (!reset) begin
         if (rsp_valid) begin
            if (lookups_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected lookup result, expected none actual %h",
                        $time, rsp_data);
            end else begin
               due = lookups_due.pop_front();
               compare_field("found", 32'(due.found), 32'(rsp_data.found));
               compare_field("origin_x", due.got_origin_x, rsp_data.got_origin_x);
               compare_field("origin_y", due.got_origin_y, rsp_data.got_origin_y);
               compare_field("origin_z", due.got_origin_z, rsp_data.got_origin_z);
               compare_field("speed_x", due.got_speed_x, rsp_data.got_speed_x);
               compare_field("speed_y", due.got_speed_y, rsp_data.got_speed_y);
               compare_field("speed_z", due.got_speed_z, rsp_data.got_speed_z);
               compare_field("angle_x", due.got_angle_x, rsp_data.got_angle_x);
               compare_field("angle_y", due.got_angle_y, rsp_data.got_angle_y);
               compare_field("angle_z", due.got_angle_z, rsp_data.got_angle_z);
               compare_field("motion_word", 32'(due.got_motion_word),
                             32'(rsp_data.got_motion_word));
            end
         end
         if (start && !busy) begin
            answer = track_ring(req_data);
            if (req_data.req_type == REQ_LOOKUP)
               lookups_due.push_back(row_fixed ? row_want : answer);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic issue(input req_item_type item, input logic fixed,
                        input rsp_item_type want, input logic quiet);
      @(negedge clock);
      if (!quiet) begin
         while ($urandom_range(99) < 34) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      row_fixed = fixed;
      row_want = want;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (lookups_due.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      req_item_type body;
      rsp_item_type want;
      logic [31:0]  game_now;
      logic [31:0]  stamp;
      int           sent;
      int           pick;
      logic         drained;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      row_fixed = 1'b0;
      row_want = '0;
      errors = 0;
      cycles = 0;
      ring_head = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         ring_time[i] = '0;
         ring_rec[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_PROBES; i++) begin
         body = build_req(REQ_SAVE, '0, PROBES[i].exp_fill);
         want = {PROBES[i].exp_found, body[REC_W-1:0]};
         issue(build_req(PROBES[i].kind, PROBES[i].stamp, PROBES[i].fill),
               PROBES[i].fixed_exp, want, 1'b0);
      end
      drain();

      // mostly rising time stamps with lookups near the present, plus noise
      game_now = $urandom;
      sent = 0;
      drained = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == 500 && !drained) begin
            drain();
            drained = 1'b1;
         end
         if ($urandom_range(199) == 0)
            game_now = $urandom;
         pick = $urandom_range(99);
         if (pick < 45) begin
            game_now = game_now + $urandom_range(60, 1);
            body = build_req(REQ_SAVE, game_now, FILL_RAND);
            sent++;
         end else if (pick < 50) begin
            body = build_req(REQ_SAVE, game_now, FILL_RAND);
         end else if (pick < 55) begin
            body = build_req(REQ_SAVE, $urandom, FILL_RAND);
            sent++;
         end else begin
            if (pick < 85)
               stamp = game_now - $urandom_range(12000, 0);
            else if (pick < 95)
               stamp = $urandom;
            else
               stamp = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            body = build_req(REQ_LOOKUP, stamp, FILL_RAND);
            sent++;
         end
         issue(body, 1'b0, '0, sent >= 300 && sent < 400);
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0 && lookups_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
